// ----- hdl/bpa_pkg.sv -----
package bpa_pkg;

    // Default number of pages the bitmap holds.
    localparam int MAX_PAGES_DEF = 4096;

    // The bitmap is kept as words of eight page bits.
    localparam int WORD_BITS = 8;
    localparam int BIT_W     = 3;

    // Page counts, cursor and scan index share one width; run ends of a free can reach
    // start_page + page_count and need one bit more.
    localparam int CNT_W     = 13;
    localparam int PG_W      = 14;
    localparam int OUT_PG_W  = 12;

    localparam logic [CNT_W-1:0] TOTAL_PAGES_RESET = 13'd4096;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_BIT,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                alloc_ok;
        logic [OUT_PG_W-1:0] first_page;
    } result_t;

endpackage

// ----- hdl/bpa_ram.sv -----
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bpa_engine.sv -----
module bpa_engine #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF,
    parameter int DEPTH     = 512,
    parameter int ADDR_W    = 9
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic [bpa_pkg::CNT_W-1:0]     page_count,
    input  logic [bpa_pkg::OUT_PG_W-1:0]  start_page,
    input  logic [bpa_pkg::CNT_W-1:0]     total_pages,
    output logic                          res_valid,
    input  logic                          res_ready,
    output bpa_pkg::result_t              result,
    output logic                          mem_re,
    output logic                          mem_we,
    output logic [ADDR_W-1:0]             mem_addr,
    output logic [bpa_pkg::WORD_BITS-1:0] mem_wdata,
    input  logic [bpa_pkg::WORD_BITS-1:0] mem_rdata
);

    localparam int CW = bpa_pkg::CNT_W;
    localparam int PW = bpa_pkg::PG_W;
    localparam int BW = bpa_pkg::BIT_W;
    localparam int WB = bpa_pkg::WORD_BITS;
    localparam int WI = PW - BW;
    localparam int OW = bpa_pkg::OUT_PG_W;

    bpa_pkg::state_t state_reg, state_next;

    logic [ADDR_W-1:0] init_reg;
    logic [CW-1:0]     cursor_reg;
    logic [CW-1:0]     idx_reg;
    logic [CW-1:0]     run_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     limit_reg;
    logic [CW-1:0]     lim_reg;
    logic              pass2_reg;
    logic              set_reg;
    logic [PW-1:0]     lo_reg;
    logic [PW-1:0]     hi_reg;
    logic [WI-1:0]     wrd_reg;
    logic [WI-1:0]     last_reg;
    logic              res_ok_reg;
    logic [OW-1:0]     res_first_reg;

    logic [CW-1:0] lim_in;
    logic [PW-1:0] free_lo;
    logic [PW-1:0] free_hi_raw;
    logic [PW-1:0] free_hi;
    logic          free_empty;
    logic          in_range;
    logic          free_bit;
    logic [CW-1:0] run_inc;
    logic [CW-1:0] idx_inc;
    logic [CW-1:0] run_start;
    logic [CW-1:0] wrap_lim;
    logic          hit;
    logic [WB-1:0] mark_mask;
    logic [PW-1:0] page_of_bit [WB];

    // Search limit and the clipped extent of a free request.
    always_comb begin
        if (32'(total_pages) < MAX_PAGES) begin
            lim_in = total_pages;
        end else begin
            lim_in = CW'(MAX_PAGES);
        end
        free_lo     = PW'(start_page);
        free_hi_raw = PW'(start_page) + PW'(page_count);
        if (32'(free_hi_raw) > MAX_PAGES) begin
            free_hi = PW'(MAX_PAGES);
        end else begin
            free_hi = free_hi_raw;
        end
        free_empty = (free_lo >= free_hi);
    end

    // One page of the search is examined per cycle.
    always_comb begin
        in_range  = (idx_reg < limit_reg);
        free_bit  = (32'(idx_reg) < MAX_PAGES) && !mem_rdata[idx_reg[BW-1:0]];
        run_inc   = run_reg + 1'b1;
        idx_inc   = idx_reg + 1'b1;
        run_start = idx_inc - cnt_reg;
        hit       = in_range && free_bit && (run_inc == cnt_reg);
        wrap_lim  = (cursor_reg < lim_reg) ? cursor_reg : lim_reg;
    end

    // Bits of the current word that fall inside the run being marked or freed.
    always_comb begin
        for (int b = 0; b < WB; b++) begin
            page_of_bit[b] = {wrd_reg, BW'(b)};
            mark_mask[b]   = (page_of_bit[b] >= lo_reg) && (page_of_bit[b] < hi_reg);
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bpa_pkg::ST_INIT: begin
                if (init_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            bpa_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (req_type == bpa_pkg::REQ_FREE) begin
                        state_next = free_empty ? bpa_pkg::ST_DONE : bpa_pkg::ST_MARK_RD;
                    end else begin
                        state_next = (page_count == '0) ? bpa_pkg::ST_DONE
                                                        : bpa_pkg::ST_SCAN_RD;
                    end
                end
            end
            bpa_pkg::ST_SCAN_RD: begin
                state_next = bpa_pkg::ST_SCAN_BIT;
            end
            bpa_pkg::ST_SCAN_BIT: begin
                if (!in_range) begin
                    state_next = pass2_reg ? bpa_pkg::ST_DONE : bpa_pkg::ST_SCAN_RD;
                end else if (hit) begin
                    state_next = bpa_pkg::ST_MARK_RD;
                end
            end
            bpa_pkg::ST_MARK_RD: begin
                state_next = bpa_pkg::ST_MARK_WR;
            end
            bpa_pkg::ST_MARK_WR: begin
                state_next = (wrd_reg == last_reg) ? bpa_pkg::ST_DONE : bpa_pkg::ST_MARK_RD;
            end
            bpa_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = bpa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = bpa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        case (state_reg)
            bpa_pkg::ST_INIT: begin
                mem_we    = 1'b1;
                mem_addr  = init_reg;
                mem_wdata = '1;
            end
            bpa_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            bpa_pkg::ST_SCAN_RD: begin
                mem_re   = 1'b1;
                mem_addr = ADDR_W'(idx_reg >> BW);
            end
            bpa_pkg::ST_SCAN_BIT: begin
                // Fetch the next word while the last bit of this one is examined.
                if (in_range && !hit && (idx_reg[BW-1:0] == '1)) begin
                    mem_re   = 1'b1;
                    mem_addr = ADDR_W'(idx_inc >> BW);
                end
            end
            bpa_pkg::ST_MARK_RD: begin
                mem_re   = 1'b1;
                mem_addr = ADDR_W'(wrd_reg);
            end
            bpa_pkg::ST_MARK_WR: begin
                mem_we    = 1'b1;
                mem_addr  = ADDR_W'(wrd_reg);
                mem_wdata = set_reg ? (mem_rdata | mark_mask) : (mem_rdata & ~mark_mask);
            end
            bpa_pkg::ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= bpa_pkg::ST_INIT;
            init_reg   <= '0;
            cursor_reg <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                bpa_pkg::ST_INIT: begin
                    init_reg <= init_reg + 1'b1;
                end
                bpa_pkg::ST_IDLE: begin
                    if (in_valid) begin
                        cnt_reg       <= page_count;
                        res_first_reg <= '0;
                        if (req_type == bpa_pkg::REQ_FREE) begin
                            set_reg    <= 1'b0;
                            res_ok_reg <= 1'b1;
                            lo_reg     <= free_lo;
                            hi_reg     <= free_hi;
                            wrd_reg    <= WI'(free_lo >> BW);
                            last_reg   <= WI'((free_hi - 1'b1) >> BW);
                        end else begin
                            res_ok_reg <= 1'b0;
                            idx_reg    <= cursor_reg;
                            run_reg    <= '0;
                            limit_reg  <= lim_in;
                            lim_reg    <= lim_in;
                            pass2_reg  <= 1'b0;
                        end
                    end
                end
                bpa_pkg::ST_SCAN_BIT: begin
                    if (!in_range) begin
                        // The first pass failed: wrap around to page 0.
                        pass2_reg <= 1'b1;
                        idx_reg   <= '0;
                        run_reg   <= '0;
                        limit_reg <= wrap_lim;
                    end else if (hit) begin
                        cursor_reg    <= idx_inc;
                        res_ok_reg    <= 1'b1;
                        res_first_reg <= run_start[OW-1:0];
                        set_reg       <= 1'b1;
                        lo_reg        <= PW'(run_start);
                        hi_reg        <= PW'(idx_inc);
                        wrd_reg       <= WI'(run_start >> BW);
                        last_reg      <= WI'(idx_reg >> BW);
                    end else begin
                        run_reg <= free_bit ? run_inc : '0;
                        idx_reg <= idx_inc;
                    end
                end
                bpa_pkg::ST_MARK_WR: begin
                    wrd_reg <= wrd_reg + 1'b1;
                end
                default: begin
                    init_reg <= init_reg;
                end
            endcase
        end
    end

    assign result.alloc_ok   = res_ok_reg;
    assign result.first_page = res_first_reg;

endmodule

// ----- hdl/bitmap_page_allocator_core.sv -----
// Page frame allocator with a one-bit-per-page used map and next-fit search.
// Requests arrive on the s_ channel (valid/ready): s_req_type selects allocate or free,
// s_page_count gives the run length, s_start_page the first page of a free.
// One result per request leaves on the m_ channel (valid/ready): m_alloc_ok and
// m_first_page. total_pages is written through cfg_wr_en/cfg_wr_data; the user
// must do so only while idle, the block does not enforce it. One request is
// processed at a time. An allocation searches page by page from the cursor to the
// search limit, then from page 0 up to the cursor if the first pass runs out, and
// marks a found run with a read and a write of each bitmap word it touches before
// handing over the result. A free clears its run the same way. The search walks
// bit-serially over the single-port bitmap memory. After reset the bitmap is
// filled with ones, one word per cycle, over all (MAX_PAGES + 7) / 8 words
// (512 by default); s_ready stays low meanwhile and the
// cursor resets to page 0. A finished result sits in the output register; while
// the receiver stalls, the next request can be accepted and processed, and only
// its own hand-over waits until that register is free.
module bitmap_page_allocator_core #(
    parameter int MAX_PAGES = bpa_pkg::MAX_PAGES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [bpa_pkg::CNT_W-1:0]    cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [bpa_pkg::CNT_W-1:0]    s_page_count,
    input  logic [bpa_pkg::OUT_PG_W-1:0] s_start_page,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_alloc_ok,
    output logic [bpa_pkg::OUT_PG_W-1:0] m_first_page
);

    localparam int DEPTH  = (MAX_PAGES + bpa_pkg::WORD_BITS - 1) / bpa_pkg::WORD_BITS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [bpa_pkg::CNT_W-1:0]     total_pages_reg;
    logic                          m_valid_reg;
    logic                          m_alloc_ok_reg;
    logic [bpa_pkg::OUT_PG_W-1:0]  m_first_page_reg;

    logic                          res_valid;
    logic                          res_ready;
    bpa_pkg::result_t              result;
    logic                          mem_re;
    logic                          mem_we;
    logic [ADDR_W-1:0]             mem_addr;
    logic [bpa_pkg::WORD_BITS-1:0] mem_wdata;
    logic [bpa_pkg::WORD_BITS-1:0] mem_rdata;

    assign res_ready = !m_valid_reg || m_ready;

    bpa_engine #(
        .MAX_PAGES (MAX_PAGES),
        .DEPTH     (DEPTH),
        .ADDR_W    (ADDR_W)
    ) u_engine (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .req_type    (s_req_type),
        .page_count  (s_page_count),
        .start_page  (s_start_page),
        .total_pages (total_pages_reg),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .result      (result),
        .mem_re      (mem_re),
        .mem_we      (mem_we),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata)
    );

    bpa_ram #(
        .WIDTH (bpa_pkg::WORD_BITS),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_pages_reg <= bpa_pkg::TOTAL_PAGES_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                total_pages_reg <= cfg_wr_data;
            end
            if (res_valid && res_ready) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // The result payload is loaded on the same transfer that sets m_valid.
    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_alloc_ok_reg   <= result.alloc_ok;
            m_first_page_reg <= result.first_page;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_alloc_ok   = m_alloc_ok_reg;
    assign m_first_page = m_first_page_reg;

endmodule
